/* rtl/rcsa_pkg.sv */
package rcsa_pkg;

  localparam int RAW_W      = 10;
  localparam int VAL_W      = 16;
  localparam int TICK_W     = 16;
  localparam int PROD_W     = RAW_W + VAL_W;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int NUM_CH     = 4;
  localparam int CH_W       = $clog2(NUM_CH);
  localparam int ZONE_W     = 4;
  localparam int ARM_W      = 2;
  localparam int LVL_W      = 2;

  localparam int IN_TDATA_W  = ((NUM_CH * RAW_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = NUM_CH * VAL_W + 2 * ZONE_W + ARM_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int OUT_LZ_LSB  = NUM_CH * VAL_W;
  localparam int OUT_RZ_LSB  = OUT_LZ_LSB + ZONE_W;
  localparam int OUT_ARM_LSB = OUT_RZ_LSB + ZONE_W;
  localparam int OUT_NOG_BIT = OUT_ARM_LSB + ARM_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RAW_MAX    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RAW_MIN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TICKS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_MODE   = 3'd5;

  localparam logic [VAL_W-1:0]  OUT_MAX_RST    = 16'd1000;
  localparam logic [VAL_W-1:0]  OUT_MIN_RST    = 16'd0;
  localparam logic [RAW_W-1:0]  RAW_MAX_RST    = 10'd100;
  localparam logic [RAW_W-1:0]  RAW_MIN_RST    = 10'd50;
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST = 16'd50;

  localparam logic [ZONE_W-1:0] ZONE_NONE       = 4'd0;
  localparam logic [ZONE_W-1:0] ZONE_BOT_LEFT   = 4'd7;
  localparam logic [ZONE_W-1:0] ZONE_BOT_RIGHT  = 4'd9;
  localparam logic [ZONE_W-1:0] ZONE_MAX        = 4'd9;

  localparam logic [ARM_W-1:0] ARM_LOCKED   = 2'd0;
  localparam logic [ARM_W-1:0] ARM_UNLOCKED = 2'd1;
  localparam logic [ARM_W-1:0] ARM_CAL      = 2'd2;

  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

  localparam int DIV10_W     = RAW_W + 8;
  localparam int DIV10_SHIFT = 11;
  localparam logic [DIV10_W-1:0] DIV10_RECIP = DIV10_W'(205);

  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] raw;
    logic [VAL_W-1:0] out_max;
    logic [VAL_W-1:0] out_min;
    logic [RAW_W-1:0] raw_max;
    logic [RAW_W-1:0] raw_min;
  } scl_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } scl_rsp_t;

  function automatic logic [RAW_W-1:0] div10(input logic [RAW_W-1:0] x);
    logic [DIV10_W-1:0] p;
    p = DIV10_W'(x) * DIV10_RECIP;
    div10 = RAW_W'(p >> DIV10_SHIFT);
  endfunction

  function automatic logic [LVL_W-1:0] level(input logic [RAW_W-1:0] raw,
                                             input logic [RAW_W:0]   lo_thr,
                                             input logic [RAW_W-1:0] hi_thr);
    if ({1'b0, raw} <= lo_thr) begin
      level = LVL_LOW;
    end else if (raw >= hi_thr) begin
      level = LVL_HIGH;
    end else begin
      level = LVL_MID;
    end
  endfunction

  function automatic logic [ZONE_W-1:0] zone_of(input logic [RAW_W-1:0] horiz,
                                                input logic [RAW_W-1:0] vert,
                                                input logic [RAW_W:0]   lo_thr,
                                                input logic [RAW_W-1:0] hi_thr);
    logic [LVL_W-1:0] col;
    logic [LVL_W-1:0] row;
    col = LVL_HIGH - level(horiz, lo_thr, hi_thr);
    row = LVL_HIGH - level(vert, lo_thr, hi_thr);
    if (horiz == '0) begin
      zone_of = ZONE_NONE;
    end else begin
      zone_of = ZONE_W'({row, 1'b0}) + ZONE_W'(row) + ZONE_W'(col) + ZONE_W'(1);
    end
  endfunction

endpackage

/* rtl/rcsa_scaler.sv */
module rcsa_scaler (
  input  logic               clk,
  input  logic               rst_n,
  input  rcsa_pkg::scl_req_t req,
  output rcsa_pkg::scl_rsp_t rsp
);

  typedef enum logic [3:0] {
    SC_IDLE = 4'b0001,
    SC_MUL  = 4'b0010,
    SC_DIV  = 4'b0100,
    SC_FIN  = 4'b1000
  } scl_state_t;

  scl_state_t state_r, state_nxt;
  logic [rcsa_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [rcsa_pkg::RAW_W-1:0]  a_r, a_nxt;
  logic [rcsa_pkg::VAL_W-1:0]  d_r, d_nxt;
  logic [rcsa_pkg::RAW_W-1:0]  span_r, span_nxt;
  logic [rcsa_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [rcsa_pkg::RAW_W-1:0]  rem_r, rem_nxt;
  logic [rcsa_pkg::VAL_W-1:0]  omin_r, omin_nxt;
  logic [rcsa_pkg::VAL_W-1:0]  omax_r, omax_nxt;
  logic [rcsa_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                        done_r, done_nxt;

  logic                        bypass;
  logic [rcsa_pkg::RAW_W:0]    rem_sh;
  logic                        q_bit;
  logic [rcsa_pkg::PROD_W:0]   sum;

  assign bypass = (req.raw_max <= req.raw_min) || (req.raw < req.raw_min) ||
                  (req.out_max < req.out_min);
  assign rem_sh = {rem_r, acc_r[rcsa_pkg::PROD_W-1]};
  assign q_bit  = rem_sh >= {1'b0, span_r};
  assign sum    = {1'b0, acc_r} + (rcsa_pkg::PROD_W+1)'(omin_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    d_nxt     = d_r;
    span_nxt  = span_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    omin_nxt  = omin_r;
    omax_nxt  = omax_r;
    value_nxt = value_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      SC_IDLE: begin
        if (req.start) begin
          omin_nxt = req.out_min;
          omax_nxt = req.out_max;
          acc_nxt  = '0;
          rem_nxt  = '0;
          a_nxt    = req.raw - req.raw_min;
          d_nxt    = req.out_max - req.out_min;
          span_nxt = req.raw_max - req.raw_min;
          cnt_nxt  = rcsa_pkg::CNT_W'(rcsa_pkg::RAW_W - 1);
          state_nxt = bypass ? SC_FIN : SC_MUL;
        end
      end
      SC_MUL: begin
        acc_nxt = {acc_r[rcsa_pkg::PROD_W-2:0], 1'b0} +
                  (a_r[rcsa_pkg::RAW_W-1] ? rcsa_pkg::PROD_W'(d_r) : '0);
        a_nxt   = {a_r[rcsa_pkg::RAW_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          cnt_nxt   = rcsa_pkg::CNT_W'(rcsa_pkg::PROD_W - 1);
          state_nxt = SC_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      SC_DIV: begin
        rem_nxt = q_bit ? rcsa_pkg::RAW_W'(rem_sh - {1'b0, span_r})
                        : rem_sh[rcsa_pkg::RAW_W-1:0];
        acc_nxt = {acc_r[rcsa_pkg::PROD_W-2:0], q_bit};
        if (cnt_r == '0) begin
          state_nxt = SC_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      SC_FIN: begin
        value_nxt = (sum > (rcsa_pkg::PROD_W+1)'(omax_r)) ? omax_r
                                                           : sum[rcsa_pkg::VAL_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = SC_IDLE;
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    a_r     <= a_nxt;
    d_r     <= d_nxt;
    span_r  <= span_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    omin_r  <= omin_nxt;
    omax_r  <= omax_nxt;
    value_r <= value_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = value_r;

endmodule

/* rtl/rc_stick_scale_and_arm_gesture.sv */
// Stick scaler and arm gesture detector. Each input transaction carries four raw stick
// readings and yields one output transaction with the four scaled values, the grid cell of
// the left and the right stick, the arm state and a no-gesture flag. Scaling runs on one
// shared bit-serial unit, a shift-add multiply followed by a restoring divide, one bit per
// cycle, channel after channel; an item passes through all four channels in turn and then
// loads the output register. A channel whose raw range is degenerate, whose output range
// is reversed or whose reading lies below raw_min skips the multiply and divide and yields
// out_min, clamped to out_max. In calibration mode no scaling is done and the accepted
// item goes straight to the output register load. The next item is taken once the result
// has moved into the output register, even while that register still waits for out_tready.
module rc_stick_scale_and_arm_gesture (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pitch_raw, throttle_raw, yaw_raw, roll_raw
  input  logic [rcsa_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pitch_scaled, throttle_scaled, yaw_scaled, roll_scaled, left_zone, right_zone,
  // arm_status, no_gesture, zero padding
  output logic [rcsa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [rcsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rcsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } top_state_t;

  logic [rcsa_pkg::VAL_W-1:0]  out_max_r, out_min_r;
  logic [rcsa_pkg::RAW_W-1:0]  raw_max_r, raw_min_r;
  logic [rcsa_pkg::TICK_W-1:0] hold_ticks_r;
  logic                        cal_r;

  top_state_t state_r, state_nxt;
  logic [rcsa_pkg::CH_W-1:0]   ch_r, ch_nxt;
  logic [rcsa_pkg::RAW_W-1:0]  raw_r [rcsa_pkg::NUM_CH];
  logic [rcsa_pkg::RAW_W-1:0]  raw_nxt [rcsa_pkg::NUM_CH];
  logic [rcsa_pkg::VAL_W-1:0]  hold_r [rcsa_pkg::NUM_CH];
  logic [rcsa_pkg::VAL_W-1:0]  hold_nxt [rcsa_pkg::NUM_CH];
  logic [rcsa_pkg::ZONE_W-1:0] lz_r, lz_nxt, rz_r, rz_nxt;
  logic                        armed_r, armed_nxt;
  logic [rcsa_pkg::TICK_W-1:0] hcnt_r, hcnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [rcsa_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                        in_acc;
  logic                        load;
  logic [rcsa_pkg::RAW_W-1:0]  rm10;
  logic [rcsa_pkg::RAW_W:0]    lo_thr;
  logic [rcsa_pkg::RAW_W-1:0]  hi_thr;
  logic [rcsa_pkg::TICK_W-1:0] hcnt_inc;
  logic                        gest_lock, gest_unlock, nog;
  logic [rcsa_pkg::ARM_W-1:0]  arm_code;

  rcsa_pkg::scl_req_t scl_req;
  rcsa_pkg::scl_rsp_t scl_rsp;

  rcsa_scaler u_scaler (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scl_req),
    .rsp   (scl_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign load       = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign rm10     = rcsa_pkg::div10(raw_max_r);
  assign lo_thr   = {1'b0, raw_min_r} + {1'b0, rm10};
  assign hi_thr   = raw_max_r - rm10;
  assign hcnt_inc = hcnt_r + 1'b1;

  assign gest_lock   = (lz_r == rcsa_pkg::ZONE_BOT_RIGHT) && (rz_r == rcsa_pkg::ZONE_BOT_LEFT);
  assign gest_unlock = (lz_r == rcsa_pkg::ZONE_BOT_LEFT) && (rz_r == rcsa_pkg::ZONE_BOT_RIGHT);
  assign nog         = !(gest_lock || gest_unlock);

  assign scl_req.start   = (state_r == ST_START);
  assign scl_req.raw     = raw_r[ch_r];
  assign scl_req.out_max = out_max_r;
  assign scl_req.out_min = out_min_r;
  assign scl_req.raw_max = raw_max_r;
  assign scl_req.raw_min = raw_min_r;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    raw_nxt       = raw_r;
    hold_nxt      = hold_r;
    lz_nxt        = lz_r;
    rz_nxt        = rz_r;
    armed_nxt     = armed_r;
    hcnt_nxt      = hcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    arm_code      = rcsa_pkg::ARM_LOCKED;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < rcsa_pkg::NUM_CH; i++) begin
            raw_nxt[i] = in_tdata[i*rcsa_pkg::RAW_W +: rcsa_pkg::RAW_W];
          end
          lz_nxt    = rcsa_pkg::zone_of(raw_nxt[2], raw_nxt[1], lo_thr, hi_thr);
          rz_nxt    = rcsa_pkg::zone_of(raw_nxt[3], raw_nxt[0], lo_thr, hi_thr);
          ch_nxt    = '0;
          state_nxt = cal_r ? ST_DONE : ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (scl_rsp.done) begin
          hold_nxt[ch_r] = scl_rsp.value;
          if (ch_r == rcsa_pkg::CH_W'(rcsa_pkg::NUM_CH - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_START;
          end
        end
      end
      ST_DONE: begin
        if (load) begin
          if (!nog) begin
            if (hcnt_inc == hold_ticks_r) begin
              hcnt_nxt = '0;
              if (!cal_r) begin
                armed_nxt = gest_unlock;
              end
            end else begin
              hcnt_nxt = hcnt_inc;
            end
          end else begin
            hcnt_nxt = '0;
          end
          if (cal_r) begin
            arm_code = rcsa_pkg::ARM_CAL;
          end else if (armed_nxt) begin
            arm_code = rcsa_pkg::ARM_UNLOCKED;
          end else begin
            arm_code = rcsa_pkg::ARM_LOCKED;
          end
          out_data_nxt  = {{rcsa_pkg::OUT_PAD_W{1'b0}}, nog, arm_code, rz_r, lz_r,
                           hold_r[3], hold_r[2], hold_r[1], hold_r[0]};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      armed_r     <= 1'b0;
      hcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < rcsa_pkg::NUM_CH; i++) begin
        hold_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      armed_r     <= armed_nxt;
      hcnt_r      <= hcnt_nxt;
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    lz_r       <= lz_nxt;
    rz_r       <= rz_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_max_r    <= rcsa_pkg::OUT_MAX_RST;
      out_min_r    <= rcsa_pkg::OUT_MIN_RST;
      raw_max_r    <= rcsa_pkg::RAW_MAX_RST;
      raw_min_r    <= rcsa_pkg::RAW_MIN_RST;
      hold_ticks_r <= rcsa_pkg::HOLD_TICKS_RST;
      cal_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcsa_pkg::REG_OUT_MAX:    out_max_r    <= cfg_wdata[rcsa_pkg::VAL_W-1:0];
        rcsa_pkg::REG_OUT_MIN:    out_min_r    <= cfg_wdata[rcsa_pkg::VAL_W-1:0];
        rcsa_pkg::REG_RAW_MAX:    raw_max_r    <= cfg_wdata[rcsa_pkg::RAW_W-1:0];
        rcsa_pkg::REG_RAW_MIN:    raw_min_r    <= cfg_wdata[rcsa_pkg::RAW_W-1:0];
        rcsa_pkg::REG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[rcsa_pkg::TICK_W-1:0];
        rcsa_pkg::REG_CAL_MODE:   cal_r        <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/rcsa_chk.sv */
module rcsa_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rcsa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [rcsa_pkg::ZONE_W-1:0] lz, rz;
  logic [rcsa_pkg::ARM_W-1:0]  arm;
  logic                        nog;

  assign lz  = out_tdata[rcsa_pkg::OUT_LZ_LSB +: rcsa_pkg::ZONE_W];
  assign rz  = out_tdata[rcsa_pkg::OUT_RZ_LSB +: rcsa_pkg::ZONE_W];
  assign arm = out_tdata[rcsa_pkg::OUT_ARM_LSB +: rcsa_pkg::ARM_W];
  assign nog = out_tdata[rcsa_pkg::OUT_NOG_BIT];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again straight after a transaction");

  a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (lz <= rcsa_pkg::ZONE_MAX) && (rz <= rcsa_pkg::ZONE_MAX))
    else $error("zone out of grid");

  a_gesture_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !nog |->
      (lz == rcsa_pkg::ZONE_BOT_RIGHT && rz == rcsa_pkg::ZONE_BOT_LEFT) ||
      (lz == rcsa_pkg::ZONE_BOT_LEFT && rz == rcsa_pkg::ZONE_BOT_RIGHT))
    else $error("gesture flagged without lock or unlock sticks");

  a_arm_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> arm == rcsa_pkg::ARM_LOCKED || arm == rcsa_pkg::ARM_UNLOCKED ||
                   arm == rcsa_pkg::ARM_CAL)
    else $error("arm status code unused");

endmodule

bind rc_stick_scale_and_arm_gesture rcsa_chk u_rcsa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_rc_stick_scale_and_arm_gesture.sv */
module tb_rc_stick_scale_and_arm_gesture;
  import rcsa_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1500;
  localparam int MAX_READING = 1000;

  typedef struct packed {
    logic [RAW_W-1:0] roll;
    logic [RAW_W-1:0] yaw;
    logic [RAW_W-1:0] throttle;
    logic [RAW_W-1:0] pitch;
  } stick_in_t;

  typedef struct packed {
    logic              no_gesture;
    logic [ARM_W-1:0]  arm_status;
    logic [ZONE_W-1:0] right_zone;
    logic [ZONE_W-1:0] left_zone;
    logic [VAL_W-1:0]  roll_scaled;
    logic [VAL_W-1:0]  yaw_scaled;
    logic [VAL_W-1:0]  throttle_scaled;
    logic [VAL_W-1:0]  pitch_scaled;
  } stick_rpt_t;

  typedef enum logic {G_LOCK, G_UNLOCK} gesture_e;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // pitch_raw, throttle_raw, yaw_raw, roll_raw
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // pitch_scaled, throttle_scaled, yaw_scaled, roll_scaled, left_zone, right_zone,
  // arm_status, no_gesture, zero padding
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  rc_stick_scale_and_arm_gesture dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [VAL_W-1:0]  r_out_max    = OUT_MAX_RST;
  logic [VAL_W-1:0]  r_out_min    = OUT_MIN_RST;
  logic [RAW_W-1:0]  r_raw_max    = RAW_MAX_RST;
  logic [RAW_W-1:0]  r_raw_min    = RAW_MIN_RST;
  logic [TICK_W-1:0] r_hold_ticks = HOLD_TICKS_RST;
  logic              r_cal        = 1'b0;

  logic              armed_q = 1'b0;
  logic [TICK_W-1:0] hold_run = '0;
  logic [VAL_W-1:0]  scaled_keep [NUM_CH] = '{default: '0};

  stick_in_t  stick_queue [$];
  stick_rpt_t due_reports [$];

  int items_queued    = 0;
  int reports_checked = 0;
  int arm_changes     = 0;
  int settings_count  = 0;
  int errors          = 0;
  int in_gap_max      = 10;
  int out_gap_max     = 10;
  int quiet_cycles    = 0;

  function automatic logic [VAL_W-1:0] scale_reading(logic [RAW_W-1:0] raw);
    longint span, num, q, v;
    span = longint'(r_raw_max) - longint'(r_raw_min);
    if (span <= 0) begin
      v = longint'(r_out_min);
    end else begin
      num = (longint'(raw) - longint'(r_raw_min)) *
            (longint'(r_out_max) - longint'(r_out_min));
      q = num / span;
      v = (q < 0) ? longint'(r_out_min) : q + longint'(r_out_min);
    end
    if (v > longint'(r_out_max)) v = longint'(r_out_max);
    return v[VAL_W-1:0];
  endfunction

  function automatic int low_top();
    return int'(r_raw_min) + int'(r_raw_max) / 10;
  endfunction

  function automatic int high_bottom();
    return int'(r_raw_max) - int'(r_raw_max) / 10;
  endfunction

  function automatic logic [LVL_W-1:0] stick_level(logic [RAW_W-1:0] raw);
    if (int'(raw) <= low_top()) return LVL_LOW;
    if (int'(raw) >= high_bottom()) return LVL_HIGH;
    return LVL_MID;
  endfunction

  function automatic logic [ZONE_W-1:0] grid_cell(logic [RAW_W-1:0] horiz,
                                                  logic [RAW_W-1:0] vert);
    int row, col;
    if (horiz == '0) return ZONE_NONE;
    row = int'(LVL_HIGH) - int'(stick_level(vert));
    col = int'(LVL_HIGH) - int'(stick_level(horiz));
    return ZONE_W'(row * 3 + col + 1);
  endfunction

  function automatic stick_rpt_t predict_report(stick_in_t s);
    stick_rpt_t r;
    logic locking, unlocking;
    if (!r_cal) begin
      scaled_keep[0] = scale_reading(s.pitch);
      scaled_keep[1] = scale_reading(s.throttle);
      scaled_keep[2] = scale_reading(s.yaw);
      scaled_keep[3] = scale_reading(s.roll);
    end
    r.left_zone  = grid_cell(s.yaw, s.throttle);
    r.right_zone = grid_cell(s.roll, s.pitch);
    locking   = (r.left_zone == ZONE_BOT_RIGHT) && (r.right_zone == ZONE_BOT_LEFT);
    unlocking = (r.left_zone == ZONE_BOT_LEFT) && (r.right_zone == ZONE_BOT_RIGHT);
    r.no_gesture = 1'b0;
    if (locking || unlocking) begin
      hold_run = hold_run + 1'b1;
      if (hold_run == r_hold_ticks) begin
        hold_run = '0;
        if (!r_cal) armed_q = unlocking;
      end
    end else begin
      hold_run = '0;
      r.no_gesture = 1'b1;
    end
    r.pitch_scaled    = scaled_keep[0];
    r.throttle_scaled = scaled_keep[1];
    r.yaw_scaled      = scaled_keep[2];
    r.roll_scaled     = scaled_keep[3];
    r.arm_status = r_cal ? ARM_CAL : (armed_q ? ARM_UNLOCKED : ARM_LOCKED);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH %s", msg);
    errors++;
  endtask

  // driver
  stick_in_t on_bus;
  int        send_gap = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        due_reports.push_back(predict_report(on_bus));
        next_valid = 1'b0;
        send_gap = $urandom_range(0, in_gap_max);
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (stick_queue.size() != 0) begin
          on_bus = stick_queue.pop_front();
          in_tdata <= IN_TDATA_W'(on_bus);
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // monitor
  int         recv_stall = 0;
  logic [ARM_W-1:0] last_arm = ARM_LOCKED;

  always @(posedge clk) begin
    stick_rpt_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = stick_rpt_t'(out_tdata[OUT_FIELD_W-1:0]);
        if (due_reports.size() == 0) begin
          flag_mismatch($sformatf("unexpected report %h", got));
        end else begin
          want = due_reports.pop_front();
          if (got.pitch_scaled != want.pitch_scaled)
            flag_mismatch($sformatf("report %0d pitch_scaled: want %0d got %0d",
                                    reports_checked, want.pitch_scaled, got.pitch_scaled));
          if (got.throttle_scaled != want.throttle_scaled)
            flag_mismatch($sformatf("report %0d throttle_scaled: want %0d got %0d",
                                    reports_checked, want.throttle_scaled,
                                    got.throttle_scaled));
          if (got.yaw_scaled != want.yaw_scaled)
            flag_mismatch($sformatf("report %0d yaw_scaled: want %0d got %0d",
                                    reports_checked, want.yaw_scaled, got.yaw_scaled));
          if (got.roll_scaled != want.roll_scaled)
            flag_mismatch($sformatf("report %0d roll_scaled: want %0d got %0d",
                                    reports_checked, want.roll_scaled, got.roll_scaled));
          if (got.left_zone != want.left_zone)
            flag_mismatch($sformatf("report %0d left_zone: want %0d got %0d",
                                    reports_checked, want.left_zone, got.left_zone));
          if (got.right_zone != want.right_zone)
            flag_mismatch($sformatf("report %0d right_zone: want %0d got %0d",
                                    reports_checked, want.right_zone, got.right_zone));
          if (got.arm_status != want.arm_status)
            flag_mismatch($sformatf("report %0d arm_status: want %0d got %0d",
                                    reports_checked, want.arm_status, got.arm_status));
          if (got.no_gesture != want.no_gesture)
            flag_mismatch($sformatf("report %0d no_gesture: want %0d got %0d",
                                    reports_checked, want.no_gesture, got.no_gesture));
          if (want.arm_status != last_arm) arm_changes++;
          last_arm = want.arm_status;
          reports_checked++;
        end
        recv_stall = $urandom_range(0, out_gap_max);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      out_tready <= (recv_stall == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sample away from the rising edge so the driver and monitor have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (stick_queue.size() != 0 || in_tvalid || due_reports.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_OUT_MAX:    r_out_max    = val;
      REG_OUT_MIN:    r_out_min    = val;
      REG_RAW_MAX:    r_raw_max    = val[RAW_W-1:0];
      REG_RAW_MIN:    r_raw_min    = val[RAW_W-1:0];
      REG_HOLD_TICKS: r_hold_ticks = val;
      REG_CAL_MODE:   r_cal        = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int omax, int omin, int rmax, int rmin, int hold, int cal);
    wait_idle();
    repeat (4) @(posedge clk);
    write_reg(REG_OUT_MAX, CFG_DATA_W'(omax));
    write_reg(REG_OUT_MIN, CFG_DATA_W'(omin));
    write_reg(REG_RAW_MAX, CFG_DATA_W'(rmax));
    write_reg(REG_RAW_MIN, CFG_DATA_W'(rmin));
    write_reg(REG_HOLD_TICKS, CFG_DATA_W'(hold));
    write_reg(REG_CAL_MODE, CFG_DATA_W'(cal));
    settings_count++;
  endtask

  function automatic logic [RAW_W-1:0] cap_reading(int v);
    return RAW_W'(v > MAX_READING ? MAX_READING : (v < 0 ? 0 : v));
  endfunction

  function automatic logic [RAW_W-1:0] pick_low(bit nonzero);
    int top;
    top = low_top() > MAX_READING ? MAX_READING : low_top();
    if (nonzero && top < 1) return RAW_W'($urandom_range(0, MAX_READING));
    return RAW_W'($urandom_range(nonzero ? 1 : 0, top));
  endfunction

  function automatic logic [RAW_W-1:0] pick_high();
    int bot;
    bot = high_bottom() > low_top() ? high_bottom() : low_top() + 1;
    if (bot > MAX_READING) return RAW_W'($urandom_range(0, MAX_READING));
    return RAW_W'($urandom_range(bot, MAX_READING));
  endfunction

  function automatic logic [RAW_W-1:0] any_reading();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAW_W'(MAX_READING);
      2: return cap_reading(low_top() + int'($urandom_range(0, 1)));
      3: return cap_reading(high_bottom() - int'($urandom_range(0, 1)));
      default: return RAW_W'($urandom_range(0, MAX_READING));
    endcase
  endfunction

  function automatic stick_in_t gesture_item(gesture_e g);
    stick_in_t s;
    s.throttle = pick_low(1'b0);
    s.pitch    = pick_low(1'b0);
    if (g == G_UNLOCK) begin
      s.yaw  = pick_high();
      s.roll = pick_low(1'b1);
    end else begin
      s.yaw  = pick_low(1'b1);
      s.roll = pick_high();
    end
    return s;
  endfunction

  task automatic push_item(stick_in_t s);
    stick_queue.push_back(s);
    items_queued++;
  endtask

  task automatic push_raw(int p, int t, int y, int r);
    stick_in_t s;
    s.pitch    = RAW_W'(p);
    s.throttle = RAW_W'(t);
    s.yaw      = RAW_W'(y);
    s.roll     = RAW_W'(r);
    push_item(s);
  endtask

  task automatic fill_items(int n);
    int       added, len, cap;
    gesture_e g;
    stick_in_t s;
    added = 0;
    cap = (r_hold_ticks != 0 && r_hold_ticks < 16) ? int'(r_hold_ticks) + 3 : 10;
    while (added < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          g = gesture_e'($urandom_range(0, 1));
          len = $urandom_range(1, cap);
          repeat (len) begin
            if ($urandom_range(0, 7) == 0) g = (g == G_LOCK) ? G_UNLOCK : G_LOCK;
            push_item(gesture_item(g));
            added++;
          end
        end
        6, 7: begin
          s.pitch = any_reading();
          s.throttle = any_reading();
          s.yaw = any_reading();
          s.roll = any_reading();
          push_item(s);
          added++;
        end
        default: begin
          // one reading moved off the gesture, which can break the hold
          s = gesture_item(gesture_e'($urandom_range(0, 1)));
          case ($urandom_range(0, 3))
            0: s.pitch    = any_reading();
            1: s.throttle = any_reading();
            2: s.yaw      = any_reading();
            default: s.roll = any_reading();
          endcase
          push_item(s);
          added++;
        end
      endcase
    end
  endtask

  task automatic random_settings();
    int omax, omin, rmax, rmin, hold, a, b;
    a = $urandom_range(0, 65535);
    b = $urandom_range(0, 65535);
    case ($urandom_range(0, 4))
      0: begin omax = 1000;  omin = 0; end
      1: begin omax = 65535; omin = 0; end
      2: begin omax = (a > b) ? a : b; omin = (a > b) ? b : a; end
      3: begin omax = (a < b) ? a : b; omin = (a < b) ? b : a; end
      default: begin omax = a; omin = a; end
    endcase
    case ($urandom_range(0, 7))
      0: begin rmax = 100;  rmin = 50; end
      1: begin rmax = 1000; rmin = 0; end
      2: begin rmin = $urandom_range(1, 999); rmax = $urandom_range(1, rmin); end
      3: begin rmax = 1;    rmin = 0; end
      4: begin rmax = 1000; rmin = 999; end
      default: begin
        rmin = $urandom_range(0, 998);
        rmax = $urandom_range(rmin + 1, 1000);
      end
    endcase
    case ($urandom_range(0, 9))
      0: hold = 0;
      1: hold = 65535;
      default: hold = $urandom_range(1, 8);
    endcase
    apply_settings(omax, omin, rmax, rmin, hold, ($urandom_range(0, 4) == 0) ? 1 : 0);
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset: no signal, rails, thresholds
    push_raw(0, 0, 0, 0);
    push_raw(1000, 1000, 1000, 1000);
    push_raw(50, 50, 50, 50);
    push_raw(100, 100, 100, 100);
    push_raw(75, 60, 61, 90);
    push_raw(89, 61, 1, 1);

    // arm, then switch straight to lock so the count carries over
    apply_settings(1000, 0, 100, 50, 3, 0);
    repeat (3) push_raw(0, 0, 1000, 10);
    repeat (2) push_raw(5, 20, 95, 60);
    push_raw(0, 0, 10, 1000);
    push_raw(0, 0, 10, 1000);

    // full ranges, largest product
    apply_settings(65535, 0, 1000, 0, 65535, 0);
    push_raw(0, 500, 1000, 999);
    push_raw(1000, 1, 512, 511);

    // reversed output range with a degenerate raw range
    apply_settings(0, 65535, 1, 999, 0, 0);
    push_raw(999, 1000, 1, 0);
    push_raw(0, 512, 1000, 1);

    // calibration holds outputs and blocks arming
    apply_settings(1000, 0, 100, 50, 2, 1);
    repeat (3) push_raw(0, 0, 1000, 10);
    push_raw(300, 700, 0, 999);

    while (items_queued < ITEM_TARGET) begin
      random_settings();
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      n = $urandom_range(80, 160);
      if ($urandom_range(0, 2) == 0) begin
        fill_items(n / 2);
        wait_idle();
        fill_items(n - n / 2);
      end else begin
        fill_items(n);
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (due_reports.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", due_reports.size()));
    $display("Ran %0d stick readings through %0d register settings, checked %0d reports,",
             items_queued, settings_count, reports_checked);
    $display("saw %0d arm status changes and %0d mismatches.", arm_changes, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
